/* rtl/lss_pkg.sv */
`default_nettype none

package lss_pkg;

    // register indexes on the configuration port
    localparam logic [2:0] CFG_TOLERANCE        = 3'd0;
    localparam logic [2:0] CFG_INITIAL_LOG      = 3'd1;
    localparam logic [2:0] CFG_INITIAL_ZERO     = 3'd2;
    localparam logic [2:0] CFG_INITIAL_STATUS   = 3'd3;
    localparam logic [2:0] CFG_LOG_STEP         = 3'd4;

    localparam logic [30:0] TOLERANCE_RESET     = 31'd66;
    localparam logic [30:0] LOG_STEP_RESET      = 31'd1599043;

    // last iteration indexes of the shared unit
    localparam logic [5:0]  MUL_LAST            = 6'd31;
    localparam logic [5:0]  DIV_LAST            = 6'd33;

    // quotient clamp, two to the power 33
    localparam logic [33:0] QUOT_LIMIT          = 34'h2_0000_0000;

    typedef enum logic [2:0] {
        MD_IDLE,
        MD_MUL,
        MD_CHK,
        MD_DIV,
        MD_DONE
    } lss_md_state_t;

    typedef enum logic {
        CTL_IDLE,
        CTL_BUSY
    } lss_ctl_state_t;

    typedef struct packed {
        logic        start;
        logic        ack;
        logic [31:0] mag_st;
        logic [32:0] mag_dl;
        logic [32:0] mag_ds;
    } lss_md_req_t;

    typedef struct packed {
        logic        done;
        logic [33:0] quot;
    } lss_md_rsp_t;

endpackage

`default_nettype wire

/* rtl/log_domain_secant_solver.sv */
// secant root search on log prices
//
// input channel (s_valid/s_ready): s_mode 1 starts a search from the
// configuration registers, s_mode 0 reports the status of the trial last
// handed out. result channel (m_valid/m_ready): one transfer per input
// transfer carrying the log of the next trial price, solved and divide
// fault flags and the trial count.
// configuration: cfg_wr_en/cfg_index/cfg_wr_data, written while idle.
//
// start, first status, solved and divide fault items give their result in
// the cycle after the input transfer. a secant step runs 32 multiply steps,
// one range check and 34 divide steps, all on one shared 34-bit adder,
// plus the commit; a quotient of two to the 34 or more skips the divide
// steps. one item is in flight at a time.
//
// a result waits in the output register while m_ready is low; a new input
// transfer is taken only once that register is free or being emptied.
// reset clears the search state and restores the register defaults.
`default_nettype none

module log_domain_secant_solver (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_wr_data,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_mode,
    input  logic signed [31:0] s_target_status,

    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_next_log_price,
    output logic               m_solved,
    output logic               m_divide_fault,
    output logic [15:0]        m_iteration_count
);

    import lss_pkg::*;

    function automatic logic [31:0] sat33(input logic [32:0] v);
        if (v[32] != v[31]) begin
            sat33 = v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            sat33 = v[31:0];
        end
    endfunction

    function automatic logic [31:0] sat35(input logic [34:0] v);
        if ((&v[34:31]) || (~|v[34:31])) begin
            sat35 = v[31:0];
        end else begin
            sat35 = v[34] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
    endfunction

    // configuration registers
    logic [30:0] tol_reg, tol_next;
    logic [31:0] init_log_reg, init_log_next;
    logic        init_zero_reg, init_zero_next;
    logic [31:0] init_stat_reg, init_stat_next;
    logic [30:0] log_step_reg, log_step_next;

    // search state
    logic [31:0] cur_log_reg, cur_log_next;
    logic [31:0] prev_log_reg, prev_log_next;
    logic [31:0] prev_stat_reg, prev_stat_next;
    logic [15:0] trial_cnt_reg, trial_cnt_next;
    logic [31:0] st_hold_reg, st_hold_next;
    logic        neg_hold_reg, neg_hold_next;

    // output register
    logic        m_valid_reg, m_valid_next;
    logic [31:0] m_log_reg, m_log_next;
    logic        m_solved_reg, m_solved_next;
    logic        m_fault_reg, m_fault_next;
    logic [15:0] m_count_reg, m_count_next;

    lss_ctl_state_t ctl_state_reg, ctl_state_next;

    lss_md_req_t md_req;
    lss_md_rsp_t md_rsp;

    logic        out_free;
    logic        s_xfer;
    logic        commit;

    // start item terms
    logic [31:0] init_mag;
    logic        init_within;
    logic        init_pos;
    logic [32:0] init_up;
    logic [32:0] init_dn;
    logic [31:0] start_log;

    // status item terms
    logic [31:0] st;
    logic [31:0] st_mag;
    logic        st_first;
    logic        st_within;
    logic        st_equal;
    logic        st_secant;
    logic [32:0] dl;
    logic [32:0] ds;
    logic [15:0] cnt_inc;

    // commit of a secant step
    logic [34:0] cur_wide;
    logic [34:0] quot_wide;
    logic [34:0] new_wide;
    logic [31:0] new_log;

    lss_muldiv u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (md_req),
        .rsp     (md_rsp)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign s_xfer   = s_valid && s_ready;

    // register write decoder
    always_comb begin
        tol_next       = tol_reg;
        init_log_next  = init_log_reg;
        init_zero_next = init_zero_reg;
        init_stat_next = init_stat_reg;
        log_step_next  = log_step_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_TOLERANCE:      tol_next       = cfg_wr_data[30:0];
                CFG_INITIAL_LOG:    init_log_next  = cfg_wr_data;
                CFG_INITIAL_ZERO:   init_zero_next = cfg_wr_data[0];
                CFG_INITIAL_STATUS: init_stat_next = cfg_wr_data;
                CFG_LOG_STEP:       log_step_next  = cfg_wr_data[30:0];
                default: ;
            endcase
        end
    end

    // seeding of a new search
    always_comb begin
        init_mag    = init_stat_reg[31] ? (~init_stat_reg + 32'd1) : init_stat_reg;
        init_within = init_mag < {1'b0, tol_reg};
        init_pos    = !init_stat_reg[31] && (|init_stat_reg);
        init_up     = {init_log_reg[31], init_log_reg} + {2'b00, log_step_reg};
        init_dn     = {init_log_reg[31], init_log_reg} - {2'b00, log_step_reg};
        if (init_zero_reg) begin
            start_log = {1'b0, log_step_reg};
        end else if (init_within) begin
            start_log = init_log_reg;
        end else if (init_pos) begin
            start_log = sat33(init_up);
        end else begin
            start_log = sat33(init_dn);
        end
    end

    // classification of a status report
    always_comb begin
        st        = s_target_status;
        st_mag    = st[31] ? (~st + 32'd1) : st;
        st_first  = (trial_cnt_reg == 16'd0);
        st_within = st_mag < {1'b0, tol_reg};
        st_equal  = (st == prev_stat_reg);
        st_secant = !st_first && !st_within && !st_equal;
        dl        = {cur_log_reg[31], cur_log_reg} - {prev_log_reg[31], prev_log_reg};
        ds        = {st[31], st} - {prev_stat_reg[31], prev_stat_reg};
        cnt_inc   = (trial_cnt_reg == 16'hFFFF) ? trial_cnt_reg : trial_cnt_reg + 16'd1;
    end

    // new trial = current minus signed quotient
    always_comb begin
        cur_wide  = {{3{cur_log_reg[31]}}, cur_log_reg};
        quot_wide = {1'b0, md_rsp.quot};
        new_wide  = neg_hold_reg ? (cur_wide + quot_wide) : (cur_wide - quot_wide);
        new_log   = sat35(new_wide);
    end

    // control next state
    always_comb begin
        ctl_state_next = ctl_state_reg;
        unique case (ctl_state_reg)
            CTL_IDLE: if (s_xfer && !s_mode && st_secant) ctl_state_next = CTL_BUSY;
            CTL_BUSY: if (md_rsp.done && out_free) ctl_state_next = CTL_IDLE;
            default:  ctl_state_next = CTL_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_ready       = 1'b0;
        commit        = 1'b0;
        md_req.start  = 1'b0;
        md_req.ack    = 1'b0;
        md_req.mag_st = st_mag;
        md_req.mag_dl = dl[32] ? (~dl + 33'd1) : dl;
        md_req.mag_ds = ds[32] ? (~ds + 33'd1) : ds;
        unique case (ctl_state_reg)
            CTL_IDLE: begin
                s_ready      = out_free;
                md_req.start = s_xfer && !s_mode && st_secant;
            end
            CTL_BUSY: begin
                commit     = md_rsp.done && out_free;
                md_req.ack = commit;
            end
            default: ;
        endcase
    end

    // search state and output register
    always_comb begin
        cur_log_next   = cur_log_reg;
        prev_log_next  = prev_log_reg;
        prev_stat_next = prev_stat_reg;
        trial_cnt_next = trial_cnt_reg;
        st_hold_next   = st_hold_reg;
        neg_hold_next  = neg_hold_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_log_next     = m_log_reg;
        m_solved_next  = m_solved_reg;
        m_fault_next   = m_fault_reg;
        m_count_next   = m_count_reg;

        if (s_xfer && s_mode) begin
            prev_stat_next = init_stat_reg;
            prev_log_next  = init_zero_reg ? 32'd0 : init_log_reg;
            cur_log_next   = start_log;
            trial_cnt_next = '0;
            m_valid_next   = 1'b1;
            m_log_next     = start_log;
            m_solved_next  = 1'b0;
            m_fault_next   = 1'b0;
            m_count_next   = '0;
        end else if (s_xfer) begin
            trial_cnt_next = cnt_inc;
            if (st_secant) begin
                // result follows when the shared unit is done
                st_hold_next  = st;
                neg_hold_next = st[31] ^ dl[32] ^ ds[32];
            end else begin
                // first report, within tolerance or equal statuses: trial held
                m_valid_next  = 1'b1;
                m_log_next    = cur_log_reg;
                m_solved_next = !st_first && st_within;
                m_fault_next  = !st_first && !st_within && st_equal;
                m_count_next  = cnt_inc;
            end
        end else if (commit) begin
            prev_log_next  = cur_log_reg;
            prev_stat_next = st_hold_reg;
            cur_log_next   = new_log;
            m_valid_next   = 1'b1;
            m_log_next     = new_log;
            m_solved_next  = 1'b0;
            m_fault_next   = 1'b0;
            m_count_next   = trial_cnt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg       <= TOLERANCE_RESET;
            init_log_reg  <= '0;
            init_zero_reg <= 1'b0;
            init_stat_reg <= '0;
            log_step_reg  <= LOG_STEP_RESET;
            cur_log_reg   <= '0;
            prev_log_reg  <= '0;
            prev_stat_reg <= '0;
            trial_cnt_reg <= '0;
            m_valid_reg   <= 1'b0;
            ctl_state_reg <= CTL_IDLE;
        end else begin
            tol_reg       <= tol_next;
            init_log_reg  <= init_log_next;
            init_zero_reg <= init_zero_next;
            init_stat_reg <= init_stat_next;
            log_step_reg  <= log_step_next;
            cur_log_reg   <= cur_log_next;
            prev_log_reg  <= prev_log_next;
            prev_stat_reg <= prev_stat_next;
            trial_cnt_reg <= trial_cnt_next;
            m_valid_reg   <= m_valid_next;
            ctl_state_reg <= ctl_state_next;
        end
        st_hold_reg  <= st_hold_next;
        neg_hold_reg <= neg_hold_next;
        m_log_reg    <= m_log_next;
        m_solved_reg <= m_solved_next;
        m_fault_reg  <= m_fault_next;
        m_count_reg  <= m_count_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_next_log_price  = m_log_reg;
    assign m_solved          = m_solved_reg;
    assign m_divide_fault    = m_fault_reg;
    assign m_iteration_count = m_count_reg;

    // no input transfer while a secant step is in the shared unit
    a_busy_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl_state_reg == CTL_BUSY |-> !s_ready)
        else $error("input taken during secant step");

    // the shared unit only finishes for a step that control is waiting on
    a_done_only_when_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        md_rsp.done |-> ctl_state_reg == CTL_BUSY)
        else $error("shared unit done while control idle");

    // solved and divide fault are exclusive
    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_solved && m_divide_fault))
        else $error("solved and divide fault both set");

    // a start item gives its result next cycle with a cleared count
    a_start_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_mode |=> m_valid && m_iteration_count == 16'd0)
        else $error("start item result missing");

endmodule

`default_nettype wire

/* rtl/lss_addsub.sv */
`default_nettype none

module lss_addsub (
    input  logic [33:0] op_a,
    input  logic [33:0] op_b,
    input  logic        op_sub,
    output logic [34:0] result
);

    // bit 34 of a subtraction is the borrow
    assign result = {1'b0, op_a} + ({1'b0, op_b} ^ {35{op_sub}}) + {34'd0, op_sub};

endmodule

`default_nettype wire

/* rtl/lss_muldiv.sv */
`default_nettype none

module lss_muldiv (
    input  logic                aclk,
    input  logic                aresetn,
    input  lss_pkg::lss_md_req_t req,
    output lss_pkg::lss_md_rsp_t rsp
);

    import lss_pkg::*;

    lss_md_state_t state_reg, state_next;
    logic [5:0]    cnt_reg, cnt_next;
    logic [32:0]   rem_reg, rem_next;
    logic [33:0]   low_reg, low_next;
    logic [32:0]   mcand_reg, mcand_next;
    logic [32:0]   dvsr_reg, dvsr_next;
    logic          ovf_reg, ovf_next;

    logic [33:0]   op_a;
    logic [33:0]   op_b;
    logic          op_sub;
    logic [34:0]   sum;
    logic          nonneg;

    lss_addsub u_addsub (
        .op_a   (op_a),
        .op_b   (op_b),
        .op_sub (op_sub),
        .result (sum)
    );

    assign nonneg = ~sum[34];

    // operand selection for the shared adder
    always_comb begin
        op_a   = '0;
        op_b   = '0;
        op_sub = 1'b0;
        unique case (state_reg)
            MD_MUL: begin
                op_a = {1'b0, rem_reg};
                op_b = low_reg[0] ? {1'b0, mcand_reg} : 34'd0;
            end
            MD_CHK: begin
                op_a   = {4'd0, rem_reg[31:2]};
                op_b   = {1'b0, dvsr_reg};
                op_sub = 1'b1;
            end
            MD_DIV: begin
                op_a   = {rem_reg, low_reg[33]};
                op_b   = {1'b0, dvsr_reg};
                op_sub = 1'b1;
            end
            default: ;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            MD_IDLE: if (req.start) state_next = MD_MUL;
            MD_MUL:  if (cnt_reg == MUL_LAST) state_next = MD_CHK;
            MD_CHK:  state_next = nonneg ? MD_DONE : MD_DIV;
            MD_DIV:  if (cnt_reg == DIV_LAST) state_next = MD_DONE;
            MD_DONE: if (req.ack) state_next = MD_IDLE;
            default: state_next = MD_IDLE;
        endcase
    end

    // datapath registers
    always_comb begin
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        low_next   = low_reg;
        mcand_next = mcand_reg;
        dvsr_next  = dvsr_reg;
        ovf_next   = ovf_reg;
        unique case (state_reg)
            MD_IDLE: begin
                if (req.start) begin
                    cnt_next   = '0;
                    rem_next   = '0;
                    low_next   = {2'b00, req.mag_st};
                    mcand_next = req.mag_dl;
                    dvsr_next  = req.mag_ds;
                    ovf_next   = 1'b0;
                end
            end
            MD_MUL: begin
                // shift-add, one multiplier bit a step
                rem_next = sum[33:1];
                low_next = {2'b00, sum[0], low_reg[31:1]};
                cnt_next = cnt_reg + 6'd1;
            end
            MD_CHK: begin
                // quotient of two to the 34 or more saturates at once
                ovf_next = nonneg;
                rem_next = {3'd0, rem_reg[31:2]};
                low_next = {rem_reg[1:0], low_reg[31:0]};
                cnt_next = '0;
            end
            MD_DIV: begin
                // restoring division, one quotient bit a step
                rem_next = nonneg ? sum[32:0] : {rem_reg[31:0], low_reg[33]};
                low_next = {low_reg[32:0], nonneg};
                cnt_next = cnt_reg + 6'd1;
            end
            default: ;
        endcase
    end

    // outputs
    always_comb begin
        rsp.done = (state_reg == MD_DONE);
        if (ovf_reg || (low_reg[33] && (|low_reg[32:0]))) begin
            rsp.quot = QUOT_LIMIT;
        end else begin
            rsp.quot = low_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= MD_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
        rem_reg   <= rem_next;
        low_reg   <= low_next;
        mcand_reg <= mcand_next;
        dvsr_reg  <= dvsr_next;
        ovf_reg   <= ovf_next;
    end

endmodule

`default_nettype wire

/* verif/tb_log_domain_secant_solver.sv */
`default_nettype none

module tb_log_domain_secant_solver;
    import lss_pkg::*;

    // input item modes
    localparam logic MODE_STATUS = 1'b0;
    localparam logic MODE_START  = 1'b1;

    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;

    // one result transfer as the solver should produce it
    typedef struct packed {
        logic signed [31:0] log_price;
        logic               solved;
        logic               fault;
        logic [15:0]        count;
    } trial_result_t;

    // block ports; the inputs are at a known value from time zero
    logic               aclk              = 1'b0;
    logic               aresetn           = 1'b0;
    logic               cfg_wr_en         = 1'b0;
    logic [2:0]         cfg_index         = '0;
    logic [31:0]        cfg_wr_data       = '0;
    logic               s_valid           = 1'b0;
    logic               s_ready;
    logic               s_mode            = 1'b0;
    logic signed [31:0] s_target_status   = '0;
    logic               m_valid;
    logic               m_ready           = 1'b0;
    logic signed [31:0] m_next_log_price;
    logic               m_solved;
    logic               m_divide_fault;
    logic [15:0]        m_iteration_count;

    // local copy of the registers, at their reset values
    logic [30:0]        tol_r             = TOLERANCE_RESET;
    logic signed [31:0] init_log_r        = '0;
    logic               init_zero_r       = 1'b0;
    logic signed [31:0] init_st_r         = '0;
    logic [30:0]        step_r            = LOG_STEP_RESET;

    // local copy of the search state, all clear after reset
    logic signed [31:0] cur_log           = '0;
    logic signed [31:0] cur_st            = '0;
    logic signed [31:0] prev_log          = '0;
    logic signed [31:0] prev_st           = '0;
    logic [15:0]        trial_n           = '0;

    trial_result_t      pending_trials[$];
    int unsigned        mismatch_count    = 0;
    // when set, neither side idles
    logic               quiet_run         = 1'b0;

    log_domain_secant_solver dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_mode            (s_mode),
        .s_target_status   (s_target_status),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_next_log_price  (m_next_log_price),
        .m_solved          (m_solved),
        .m_divide_fault    (m_divide_fault),
        .m_iteration_count (m_iteration_count)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #4000000;
        $display("** log_domain_secant_solver: FAILED **");
        $finish;
    end

    function automatic logic signed [31:0] sat32(input longint v);
        if (v > S32_MAX) return 32'sh7FFF_FFFF;
        if (v < S32_MIN) return 32'sh8000_0000;
        return 32'(v);
    endfunction

    function automatic longint unsigned mag64(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // advances the local search state by one accepted item and returns its result
    function automatic trial_result_t secant_predict(input logic mode,
                                                     input logic signed [31:0] status);
        trial_result_t  r;
        longint         s, sp, lc, lp, il, stp, dl, ds, nl;
        longint unsigned pm, q;
        logic           neg;
        r.solved = 1'b0;
        r.fault  = 1'b0;
        s   = status;
        sp  = prev_st;
        lc  = cur_log;
        lp  = prev_log;
        il  = init_log_r;
        stp = step_r;
        if (mode == MODE_START) begin
            // seed both trial points from the registers
            prev_st = init_st_r;
            cur_st  = '0;
            if (init_zero_r) begin
                // zero first guess: search starts one log step above price one
                prev_log = '0;
                cur_log  = sat32(stp);
            end else begin
                prev_log = init_log_r;
                if (mag64(init_st_r) < tol_r) cur_log = init_log_r;
                else if (init_st_r > 0)       cur_log = sat32(il + stp);
                else                          cur_log = sat32(il - stp);
            end
            trial_n = '0;
        end else begin
            if (trial_n == 16'd0) begin
                // first report after a start: trial handed out again, status unused
            end else if (mag64(s) < tol_r) begin
                r.solved = 1'b1;
                cur_st   = status;
            end else if (s == sp) begin
                // flat secant, nothing to divide by: trial and previous point held
                r.fault = 1'b1;
                cur_st  = status;
            end else begin
                dl  = lc - lp;
                ds  = s - sp;
                pm  = mag64(s) * mag64(dl);
                q   = pm / mag64(ds);
                neg = ((s < 0) != (dl < 0)) != (ds < 0);
                if (q > QUOT_LIMIT) q = QUOT_LIMIT;
                nl  = neg ? lc + longint'(q) : lc - longint'(q);
                prev_log = cur_log;
                prev_st  = status;
                cur_log  = sat32(nl);
                cur_st   = '0;
            end
            if (trial_n != 16'hFFFF) trial_n = trial_n + 16'd1;
        end
        r.log_price = cur_log;
        r.count     = trial_n;
        return r;
    endfunction

    // register write, only ever issued while the solver is idle
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        @(posedge aclk);
        case (idx)
            CFG_TOLERANCE:      tol_r       = data[30:0];
            CFG_INITIAL_LOG:    init_log_r  = data;
            CFG_INITIAL_ZERO:   init_zero_r = data[0];
            CFG_INITIAL_STATUS: init_st_r   = data;
            CFG_LOG_STEP:       step_r      = data[30:0];
            default: ;
        endcase
    endtask

    // one input transfer; valid is left high so a back-to-back item needs no extra edge
    task automatic send_item(input logic mode, input logic signed [31:0] status);
        int unsigned gap;
        gap = quiet_run ? 0 : $urandom_range(0, 11);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_mode          <= mode;
        s_target_status <= status;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        pending_trials.push_back(secant_predict(mode, status));
    endtask

    // sender holds off until every result is back
    task automatic wait_all_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_trials.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // status reports straight out of reset, before any start
    task automatic test_reset_state();
        wait_all_results();
        send_item(MODE_STATUS, 32'sh1234_5678);   // first report, status unused
        send_item(MODE_STATUS, 32'sd0);           // inside default tolerance
        send_item(MODE_STATUS, 32'sh7FFF_FFFF);   // equal logs, trial stays put
        send_item(MODE_STATUS, 32'sh8000_0000);   // most negative status
    endtask

    // every way a start can seed the two trial points
    task automatic test_start_seeding();
        wait_all_results();
        write_reg(CFG_INITIAL_ZERO, 32'd1);
        write_reg(CFG_LOG_STEP, 32'h7FFF_FFFF);
        send_item(MODE_START, 32'sd0);
        send_item(MODE_STATUS, 32'sh5A5A_5A5A);

        // first guess already within tolerance
        wait_all_results();
        write_reg(CFG_INITIAL_ZERO, 32'd0);
        write_reg(CFG_INITIAL_LOG, 32'h8000_0000);
        write_reg(CFG_INITIAL_STATUS, 32'd65);
        send_item(MODE_START, 32'sh7FFF_FFFF);

        // step up, saturating at the top
        wait_all_results();
        write_reg(CFG_INITIAL_LOG, 32'h7FFF_FFFF);
        write_reg(CFG_INITIAL_STATUS, 32'h7FFF_FFFF);
        send_item(MODE_START, 32'sd0);

        // step down, saturating at the bottom
        wait_all_results();
        write_reg(CFG_INITIAL_LOG, 32'h8000_0000);
        write_reg(CFG_INITIAL_STATUS, 32'h8000_0000);
        send_item(MODE_START, 32'sd0);

        // zero tolerance: a zero status still steps down
        wait_all_results();
        write_reg(CFG_TOLERANCE, 32'd0);
        write_reg(CFG_INITIAL_LOG, 32'd0);
        write_reg(CFG_INITIAL_STATUS, 32'd0);
        send_item(MODE_START, 32'sd0);
    endtask

    // repeated status gives a divide fault and holds the trial
    task automatic test_divide_fault();
        wait_all_results();
        write_reg(CFG_TOLERANCE, {1'b0, TOLERANCE_RESET});
        write_reg(CFG_LOG_STEP, {1'b0, LOG_STEP_RESET});
        write_reg(CFG_INITIAL_STATUS, 32'd1000);
        send_item(MODE_START, 32'sd0);
        send_item(MODE_STATUS, 32'sd77);
        send_item(MODE_STATUS, 32'sd1000);
        send_item(MODE_STATUS, 32'sd1000);
        send_item(MODE_STATUS, 32'sd5);
    endtask

    // quotient clamp and saturation of the new trial at both ends
    task automatic test_secant_saturation();
        wait_all_results();
        write_reg(CFG_LOG_STEP, 32'h7FFF_FFFF);
        write_reg(CFG_INITIAL_STATUS, 32'h7FFF_FFFF);
        send_item(MODE_START, 32'sd0);
        send_item(MODE_STATUS, 32'sd0);
        send_item(MODE_STATUS, 32'sh7FFF_FFFE);

        wait_all_results();
        write_reg(CFG_INITIAL_STATUS, 32'h8000_0001);
        send_item(MODE_START, 32'sd0);
        send_item(MODE_STATUS, 32'sd0);
        send_item(MODE_STATUS, 32'sh8000_0000);
        send_item(MODE_STATUS, 32'sh7FFF_FFFF);
    endtask

    // widest tolerance: only the two largest magnitudes escape it
    task automatic test_tolerance_limits();
        wait_all_results();
        write_reg(CFG_TOLERANCE, 32'hFFFF_FFFF);
        write_reg(CFG_INITIAL_STATUS, 32'h0000_0100);
        send_item(MODE_START, 32'sd0);
        send_item(MODE_STATUS, 32'sd0);
        send_item(MODE_STATUS, 32'sh8000_0001);
        send_item(MODE_STATUS, 32'sh7FFF_FFFE);
    endtask

    // random configurations, each driving searches against a linear status curve
    task automatic test_random_search();
        int     sent;
        int     run_len;
        int     pick;
        longint root, slope, lc, v;
        for (int phase = 0; phase < 12; phase++) begin
            wait_all_results();
            quiet_run = (phase % 4 == 3);
            case ($urandom_range(0, 5))
                0:       write_reg(CFG_TOLERANCE, 32'd0);
                1:       write_reg(CFG_TOLERANCE, 32'h7FFF_FFFF);
                2:       write_reg(CFG_TOLERANCE, $urandom);
                default: write_reg(CFG_TOLERANCE, $urandom_range(0, 65536));
            endcase
            case ($urandom_range(0, 3))
                0:       write_reg(CFG_INITIAL_LOG, 32'h7FFF_FFFF);
                1:       write_reg(CFG_INITIAL_LOG, 32'h8000_0000);
                default: write_reg(CFG_INITIAL_LOG, $urandom);
            endcase
            write_reg(CFG_INITIAL_ZERO, $urandom);
            case ($urandom_range(0, 3))
                0:       write_reg(CFG_INITIAL_STATUS, 32'd0);
                1:       write_reg(CFG_INITIAL_STATUS, $urandom_range(0, 128));
                default: write_reg(CFG_INITIAL_STATUS, $urandom);
            endcase
            case ($urandom_range(0, 3))
                0:       write_reg(CFG_LOG_STEP, 32'h7FFF_FFFF);
                1:       write_reg(CFG_LOG_STEP, {1'b0, LOG_STEP_RESET});
                2:       write_reg(CFG_LOG_STEP, $urandom_range(0, 1 << 24));
                default: write_reg(CFG_LOG_STEP, $urandom);
            endcase

            sent = 0;
            while (sent < 125) begin
                send_item(MODE_START, $urandom);
                sent++;
                run_len = $urandom_range(1, 12);
                // root somewhere near the first guess, slope of either sign
                root  = init_log_r + ($signed($urandom) >>> 5);
                slope = $urandom_range(1, 8192);
                if ($urandom_range(0, 1)) slope = -slope;
                for (int j = 0; j < run_len; j++) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 70) begin
                        // well-behaved curve with a little noise
                        lc = cur_log;
                        v  = ((lc - root) * slope) >>> 12;
                        v  = v + int'($urandom_range(0, 4)) - 2;
                        send_item(MODE_STATUS, sat32(v));
                    end else if (pick < 82) begin
                        send_item(MODE_STATUS, $urandom);
                    end else if (pick < 94) begin
                        // same status as the previous point
                        send_item(MODE_STATUS, prev_st);
                    end else begin
                        // search restarted half way
                        send_item(MODE_START, $urandom);
                    end
                    sent++;
                end
            end
        end
        quiet_run = 1'b0;
    endtask

    // result side: random back-pressure, then compare against the oldest expectation
    initial begin : result_check
        int unsigned   stall;
        trial_result_t want;
        wait (aresetn === 1'b1);
        forever begin
            stall = quiet_run ? 0 : $urandom_range(0, 11);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (m_valid !== 1'b1) @(posedge aclk);
            if (pending_trials.size() == 0) begin
                $error("result transfer with nothing expected");
                mismatch_count++;
            end else begin
                want = pending_trials.pop_front();
                if (m_next_log_price !== want.log_price) begin
                    $error("next_log_price: expected %0d, got %0d",
                           $signed(want.log_price), m_next_log_price);
                    mismatch_count++;
                end
                if (m_solved !== want.solved) begin
                    $error("solved: expected %0b, got %0b", want.solved, m_solved);
                    mismatch_count++;
                end
                if (m_divide_fault !== want.fault) begin
                    $error("divide_fault: expected %0b, got %0b", want.fault, m_divide_fault);
                    mismatch_count++;
                end
                if (m_iteration_count !== want.count) begin
                    $error("iteration_count: expected %0d, got %0d",
                           want.count, m_iteration_count);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_state();
        test_start_seeding();
        test_divide_fault();
        test_secant_saturation();
        test_tolerance_limits();
        test_random_search();

        // drain, then allow for a full secant step before judging
        wait_all_results();
        repeat (100) @(posedge aclk);
        if (mismatch_count == 0 && pending_trials.size() == 0) begin
            $display("** log_domain_secant_solver: PASSED **");
        end else begin
            $display("** log_domain_secant_solver: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire
